/* sv/mte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker package
// Shared widths, register indexes, back-end states and the queue entry type.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int ANGLE_BITS  = 14;
  localparam int TURN_BITS   = 18;
  localparam int RAW_BITS    = 16;
  localparam int POS_BITS    = 32;
  localparam int EXT_BITS    = 64 - ANGLE_BITS - TURN_BITS;
  localparam int DIFF_BITS   = POS_BITS + 1;
  localparam int SCALE_BITS  = 15;
  localparam int PROD_BITS   = DIFF_BITS + SCALE_BITS;
  localparam int DEN_BITS    = DIFF_BITS - 1;
  localparam int QUO_BITS    = 16;
  localparam int CNT_BITS    = $clog2(QUO_BITS);
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam logic [SCALE_BITS-1:0] PCT_SCALE = SCALE_BITS'(25600);

  localparam logic signed [ANGLE_BITS:0] HALF_LIMIT =
    (ANGLE_BITS+1)'((1 << (ANGLE_BITS - 1)) - 1);
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  localparam logic signed [QUO_BITS-1:0] PCT_MAX = {1'b0, {(QUO_BITS-1){1'b1}}};
  localparam logic signed [QUO_BITS-1:0] PCT_MIN = {1'b1, {(QUO_BITS-1){1'b0}}};

  localparam logic [1:0] REG_ABS_MODE  = 2'd0;
  localparam logic [1:0] REG_RANGE_MIN = 2'd1;
  localparam logic [1:0] REG_RANGE_MAX = 2'd2;

  localparam logic signed [POS_BITS-1:0] RANGE_MAX_RESET = POS_BITS'(16383);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ABS,
    BK_CHK,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0]  position;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [DIFF_BITS-1:0] span;
    logic                        span_zero;
  } mte_job_t;

  function automatic logic signed [POS_BITS-1:0] mte_track(
    input logic signed [TURN_BITS-1:0] turn,
    input logic [ANGLE_BITS-1:0]       angle
  );
    logic [63:0] full;
    full = {{EXT_BITS{turn[TURN_BITS-1]}}, turn, angle};
    return full[POS_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/mte_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker front end
// Unwraps samples into turn and angle unless absolute; builds the percent job.
// ----------------------------------------------------------------------------
module mte_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [mte_pkg::RAW_BITS-1:0]       in_raw_word,
  input  wire logic                               absolute_mode,
  input  wire logic signed [mte_pkg::POS_BITS-1:0] range_minimum,
  input  wire logic signed [mte_pkg::POS_BITS-1:0] range_maximum,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output mte_pkg::mte_job_t                       q_job
);
  import mte_pkg::*;

  logic [ANGLE_BITS-1:0]        last_r, last_nxt;
  logic signed [TURN_BITS-1:0]  turn_r, turn_nxt;
  logic                         first_r, first_nxt;

  logic [ANGLE_BITS-1:0]        angle;
  logic signed [ANGLE_BITS:0]   delta;
  logic                         step_up;
  logic                         step_down;
  logic signed [TURN_BITS-1:0]  turn_upd;
  logic signed [POS_BITS-1:0]   track;
  logic                         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign angle    = in_raw_word[ANGLE_BITS-1:0];
  assign delta    = $signed({1'b0, last_r}) - $signed({1'b0, angle});
  assign step_up   = !first_r && (delta > HALF_LIMIT) && (turn_r != TURN_MAX);
  assign step_down = !first_r && (delta < -HALF_LIMIT) && (turn_r != TURN_MIN);

  always_comb begin
    turn_upd = turn_r;
    if (step_up) begin
      turn_upd = turn_r + TURN_BITS'(1);
    end else if (step_down) begin
      turn_upd = turn_r - TURN_BITS'(1);
    end
  end

  always_comb begin
    last_nxt  = last_r;
    turn_nxt  = turn_r;
    first_nxt = first_r;
    if (accept && !absolute_mode) begin
      last_nxt  = angle;
      turn_nxt  = turn_upd;
      first_nxt = 1'b0;
    end
  end

  always_comb begin
    if (absolute_mode) begin
      track             = mte_track(turn_r, last_r);
      q_job.position    = $signed(POS_BITS'(angle));
    end else begin
      track             = mte_track(turn_upd, angle);
      q_job.position    = track;
    end
    q_job.diff      = DIFF_BITS'(track) - DIFF_BITS'(range_minimum);
    q_job.span      = DIFF_BITS'(range_maximum) - DIFF_BITS'(range_minimum);
    q_job.span_zero = (range_maximum == range_minimum);
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      turn_r  <= '0;
      first_r <= 1'b1;
    end else begin
      last_r  <= last_nxt;
      turn_r  <= turn_nxt;
      first_r <= first_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/mte_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker job queue
// Short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
module mte_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  mte_pkg::mte_job_t      push_job,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output mte_pkg::mte_job_t      head_job
);
  import mte_pkg::*;

  mte_job_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;

  localparam logic [QPTR_BITS-1:0] LAST_PTR = QPTR_BITS'(QUEUE_DEPTH - 1);

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/mte_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker back end
// Scales the offset, divides by the span one quotient bit per cycle (skipped
// for a zero span or overflow), saturates the percent and presents the result.
// ----------------------------------------------------------------------------
module mte_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_pop,
  input  mte_pkg::mte_job_t                        q_job,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mte_pkg::POS_BITS-1:0]      out_position,
  output logic signed [mte_pkg::QUO_BITS-1:0]      out_percent_scaled,
  output logic                                     out_span_zero
);
  import mte_pkg::*;

  bk_state_t                    state_r, state_nxt;

  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [DIFF_BITS-1:0]  span_r;
  logic                         zero_r;
  logic signed [POS_BITS-1:0]   pos_r;
  logic [PROD_BITS-1:0]         num_mag_r;
  logic [DEN_BITS-1:0]          den_mag_r;
  logic                         neg_r;
  logic                         sat_r;
  logic [DEN_BITS-1:0]          rem_r;
  logic [QUO_BITS-1:0]          num_lo_r;
  logic [QUO_BITS-1:0]          quo_r;
  logic [CNT_BITS-1:0]          cnt_r;
  logic signed [QUO_BITS-1:0]   pct_r;

  logic signed [PROD_BITS:0]    prod_full;
  logic [PROD_BITS-1:0]         prod_abs;
  logic [DIFF_BITS-1:0]         span_abs;
  logic                         over;
  logic [DEN_BITS:0]            trial;
  logic                         trial_ge;
  logic signed [QUO_BITS-1:0]   pct_fin;

  assign prod_full = q_job.diff * $signed({1'b0, PCT_SCALE});
  assign prod_abs  = prod_r[PROD_BITS-1] ? PROD_BITS'(-prod_r) : PROD_BITS'(prod_r);
  assign span_abs  = span_r[DIFF_BITS-1] ? DIFF_BITS'(-span_r) : DIFF_BITS'(span_r);
  assign over      = (num_mag_r >= {den_mag_r, {QUO_BITS{1'b0}}});
  assign trial     = {rem_r, num_lo_r[QUO_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, den_mag_r});

  always_comb begin
    if (zero_r) begin
      pct_fin = '0;
    end else if (sat_r) begin
      pct_fin = neg_r ? PCT_MIN : PCT_MAX;
    end else if (neg_r) begin
      pct_fin = (quo_r > QUO_BITS'(PCT_MIN)) ? PCT_MIN : $signed(QUO_BITS'(-quo_r));
    end else begin
      pct_fin = (quo_r > QUO_BITS'(PCT_MAX)) ? PCT_MAX : $signed(quo_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_ABS;
      BK_ABS:  state_nxt = zero_r ? BK_FIN : BK_CHK;
      BK_CHK:  state_nxt = over ? BK_FIN : BK_DIV;
      BK_DIV:  if (cnt_r == CNT_BITS'(QUO_BITS - 1)) state_nxt = BK_FIN;
      BK_FIN:  state_nxt = BK_OUT;
      BK_OUT:  if (out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_OUT:  out_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        prod_r <= prod_full[PROD_BITS-1:0];
        span_r <= q_job.span;
        zero_r <= q_job.span_zero;
        pos_r  <= q_job.position;
      end
      BK_ABS: begin
        num_mag_r <= prod_abs;
        den_mag_r <= span_abs[DEN_BITS-1:0];
        neg_r     <= prod_r[PROD_BITS-1] ^ span_r[DIFF_BITS-1];
      end
      BK_CHK: begin
        sat_r    <= over;
        rem_r    <= num_mag_r[PROD_BITS-1:QUO_BITS];
        num_lo_r <= num_mag_r[QUO_BITS-1:0];
        quo_r    <= '0;
        cnt_r    <= '0;
      end
      BK_DIV: begin
        rem_r    <= trial_ge ? DEN_BITS'(trial - {1'b0, den_mag_r}) : trial[DEN_BITS-1:0];
        quo_r    <= {quo_r[QUO_BITS-2:0], trial_ge};
        num_lo_r <= {num_lo_r[QUO_BITS-2:0], 1'b0};
        cnt_r    <= cnt_r + CNT_BITS'(1);
      end
      BK_FIN: begin
        pct_r <= pct_fin;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_position       = pos_r;
  assign out_percent_scaled = pct_r;
  assign out_span_zero      = zero_r;

endmodule
`default_nettype wire

/* sv/multiturn_encoder_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker
// Unwraps 14-bit absolute encoder samples into a 32-bit position and reports
// the position as percent of a programmable range, times 256.
// ----------------------------------------------------------------------------
// Each transfer on the input returns one result. The front end takes a sample
// and queues it; the back end then reads the queue, scales the offset, takes
// magnitudes, checks the range, runs the 16 steps of the restoring divider,
// saturates and presents the percent. It skips the range check and divider
// when the span is zero and the divider when the percent saturates, and holds
// its result until taken. Up to two samples wait in the queue meanwhile. Write
// the range and mode registers only while no sample is in flight.
module multiturn_encoder_tracker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         in_raw_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_position,
  output logic signed [15:0]       out_percent_scaled,
  output logic                     out_span_zero,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import mte_pkg::*;

  logic                        abs_mode_r;
  logic signed [POS_BITS-1:0]  range_min_r;
  logic signed [POS_BITS-1:0]  range_max_r;
  logic                        cfg_write;
  logic [1:0]                  reg_index;

  logic                        q_full;
  logic                        q_push;
  logic                        q_valid;
  logic                        q_pop;
  mte_job_t                    push_job;
  mte_job_t                    head_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_mode_r  <= 1'b0;
      range_min_r <= '0;
      range_max_r <= RANGE_MAX_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ABS_MODE:  abs_mode_r  <= pwdata[0];
        REG_RANGE_MIN: range_min_r <= $signed(pwdata);
        REG_RANGE_MAX: range_max_r <= $signed(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ABS_MODE:  prdata = {{(DATA_BITS-1){1'b0}}, abs_mode_r};
      REG_RANGE_MIN: prdata = range_min_r;
      REG_RANGE_MAX: prdata = range_max_r;
      default:       prdata = '0;
    endcase
  end

  mte_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_word   (in_raw_word),
    .absolute_mode (abs_mode_r),
    .range_minimum (range_min_r),
    .range_maximum (range_max_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  mte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  mte_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_job              (head_job),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_position       (out_position),
    .out_percent_scaled (out_percent_scaled),
    .out_span_zero      (out_span_zero)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Queue written while full.");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("Queue read while empty.");

  a_zero_span_pct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_zero) |-> (out_percent_scaled == 16'sd0))
    else $error("Percent is not zero for a zero span.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && !q_pop))
    else $error("Back end left a result that was not taken.");
`endif

endmodule
`default_nettype wire
